/* sv/circular_double_ended_queue_defines.svh */
// ----------------------------------------------------------------------------
// circular_double_ended_queue_defines
// assertion macros used by the checker file of the deque
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CDQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CDQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// types, codes and index helpers of the circular double-ended queue
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH    = 8;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_idx LAST_IDX = t_idx'(DEPTH - 1);
    localparam t_idx ZERO_IDX = t_idx'(0);

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // access bundle from the control logic to the entry store
    typedef struct packed {
        logic  wr_en;
        t_idx  wr_addr;
        t_data wr_data;
        logic  rd_en;
        t_idx  rd_addr_front;
        t_idx  rd_addr_rear;
    } t_store_req;

    // index step forward with wrap
    function automatic t_idx idx_next(input t_idx i);
        return (i == LAST_IDX) ? ZERO_IDX : i + t_idx'(1);
    endfunction

    // index step back with wrap
    function automatic t_idx idx_prev(input t_idx i);
        return (i == ZERO_IDX) ? LAST_IDX : i - t_idx'(1);
    endfunction

endpackage

/* sv/cdq_req_if.sv */
// ----------------------------------------------------------------------------
// cdq_req_if
// request channel of the deque: request code and push value
// ----------------------------------------------------------------------------
interface cdq_req_if;
    import cdq_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    t_data            push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

/* sv/cdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdq_rsp_if
// result channel of the deque: status, end values and flags
// ----------------------------------------------------------------------------
interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    t_data               front_value;
    t_data               rear_value;
    logic                values_valid;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, output status, output front_value, output rear_value,
                    output values_valid, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input front_value, input rear_value,
                    input values_valid, input is_empty, input is_full, output ready);
endinterface

/* sv/cdq_store.sv */
// ----------------------------------------------------------------------------
// cdq_store
// entry store: one write port, two registered read ports, write-first
// ----------------------------------------------------------------------------
module cdq_store (
    input  logic               i_clk,
    input  cdq_pkg::t_store_req i_acc,
    output cdq_pkg::t_data     o_rd_front,
    output cdq_pkg::t_data     o_rd_rear
);
    import cdq_pkg::*;

    t_data r_mem [DEPTH];
    t_data r_rd_front;
    t_data r_rd_rear;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_acc.wr_en) begin
            r_mem[i_acc.wr_addr] <= i_acc.wr_data;
        end
    end

    // read ports, a same-cycle write to the read address is passed through
    always_ff @(posedge i_clk) begin
        if (i_acc.rd_en) begin
            if (i_acc.wr_en && (i_acc.wr_addr == i_acc.rd_addr_front)) begin
                r_rd_front <= i_acc.wr_data;
            end else begin
                r_rd_front <= r_mem[i_acc.rd_addr_front];
            end
            if (i_acc.wr_en && (i_acc.wr_addr == i_acc.rd_addr_rear)) begin
                r_rd_rear <= i_acc.wr_data;
            end else begin
                r_rd_rear <= r_mem[i_acc.rd_addr_rear];
            end
        end
    end

    assign o_rd_front = r_rd_front;
    assign o_rd_rear  = r_rd_rear;
endmodule

/* sv/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// index and flag update per request, store access, result register
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cdq_req_if.sink             i_req,
    cdq_rsp_if.source           o_rsp,
    output cdq_pkg::t_store_req o_acc,
    input  cdq_pkg::t_data      i_rd_front,
    input  cdq_pkg::t_data      i_rd_rear
);
    import cdq_pkg::*;

    t_idx    r_front, n_front;
    t_idx    r_rear, n_rear;
    logic    r_empty, n_empty;
    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;

    logic    w_accept;
    logic    w_full;
    t_req    w_req;

    // a new beat is taken once the result register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_req       = t_req'(i_req.req_type);

    // full when the slot after the rear is the front
    assign w_full = !r_empty && (idx_next(r_rear) == r_front);

    // next indices, flags and store access
    always_comb begin
        n_front        = r_front;
        n_rear         = r_rear;
        n_empty        = r_empty;
        n_status       = ST_OK;
        o_acc.wr_en    = 1'b0;
        o_acc.wr_addr  = r_front;
        o_acc.wr_data  = i_req.push_value;
        unique case (w_req) inside
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else if (r_empty) begin
                    n_front       = ZERO_IDX;
                    n_rear        = ZERO_IDX;
                    n_empty       = 1'b0;
                    o_acc.wr_en   = 1'b1;
                    o_acc.wr_addr = ZERO_IDX;
                end else if (w_req == REQ_PUSH_FRONT) begin
                    n_front       = idx_prev(r_front);
                    o_acc.wr_en   = 1'b1;
                    o_acc.wr_addr = idx_prev(r_front);
                end else begin
                    n_rear        = idx_next(r_rear);
                    o_acc.wr_en   = 1'b1;
                    o_acc.wr_addr = idx_next(r_rear);
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_empty) begin
                    n_status = ST_UNDERFLOW;
                end else if (r_front == r_rear) begin
                    n_empty = 1'b1;
                    n_front = ZERO_IDX;
                    n_rear  = ZERO_IDX;
                end else if (w_req == REQ_POP_FRONT) begin
                    n_front = idx_next(r_front);
                end else begin
                    n_rear = idx_prev(r_rear);
                end
            end
        endcase
        // state only moves on an accepted beat
        if (!w_accept) begin
            n_front     = r_front;
            n_rear      = r_rear;
            n_empty     = r_empty;
            n_status    = r_status;
            o_acc.wr_en = 1'b0;
        end
        // end values are read at the indices left by the request
        o_acc.rd_en         = w_accept;
        o_acc.rd_addr_front = n_front;
        o_acc.rd_addr_rear  = n_rear;
    end

    // result register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= ZERO_IDX;
            r_rear      <= ZERO_IDX;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    // result beat, end values forced to zero on an empty queue
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.front_value  = r_empty ? t_data'(0) : i_rd_front;
    assign o_rsp.rear_value   = r_empty ? t_data'(0) : i_rd_rear;
    assign o_rsp.values_valid = !r_empty;
    assign o_rsp.is_empty     = r_empty;
    assign o_rsp.is_full      = w_full;
endmodule

/* sv/circular_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// double-ended queue over a circular entry store, one result per request
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_req     in   req_type, push_value
//  o_rsp     out  status, front_value, rear_value, values_valid, is_empty, is_full
//
//  one request per cycle unless a result beat waits; its result appears in the
//  cycle after acceptance, from the registered read of the entry store
//  a request is taken in the same cycle the previous result beat leaves
//  reset empties the queue at once; entry contents are not cleared
//  while a result beat waits untaken, i_req.ready stays low
// ----------------------------------------------------------------------------
module circular_double_ended_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_req_if.sink   i_req,
    cdq_rsp_if.source o_rsp
);
    import cdq_pkg::*;

    t_store_req w_acc;
    t_data      w_rd_front;
    t_data      w_rd_rear;

    // request handling and result register
    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .o_acc      (w_acc),
        .i_rd_front (w_rd_front),
        .i_rd_rear  (w_rd_rear)
    );

    // entry store
    cdq_store u_store (
        .i_clk      (i_clk),
        .i_acc      (w_acc),
        .o_rd_front (w_rd_front),
        .o_rd_rear  (w_rd_rear)
    );
endmodule

/* sv/cdq_checker.sv */
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks of the deque result channel
// ----------------------------------------------------------------------------
`include "circular_double_ended_queue_defines.svh"

module cdq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [cdq_pkg::STATUS_W-1:0] i_status,
    input cdq_pkg::t_data               i_front_value,
    input cdq_pkg::t_data               i_rear_value,
    input logic                         i_values_valid,
    input logic                         i_is_empty,
    input logic                         i_is_full
);
    import cdq_pkg::*;

    // value flag mirrors the empty flag
    `CDQ_ASSERT_IMPLY(a_valid_flag, i_clk, i_rst_n, i_rsp_valid, i_values_valid == !i_is_empty, "values_valid disagrees with is_empty")

    // a full queue is never empty
    `CDQ_ASSERT_IMPLY(a_full_not_empty, i_clk, i_rst_n, i_rsp_valid && i_is_full, !i_is_empty, "full and empty together")

    // an empty queue shows zero end values
    `CDQ_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, i_rsp_valid && i_is_empty, (i_front_value == 0) && (i_rear_value == 0), "non-zero end value on empty queue")

    // overflow only happens on a full queue, which stays full
    `CDQ_ASSERT_IMPLY(a_overflow_full, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_OVERFLOW), i_is_full, "overflow reported on a queue not full")

    // a stalled result beat holds
    `CDQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_front_value) && $stable(i_rear_value) && $stable(i_is_empty) && $stable(i_is_full), "result beat changed while stalled")
endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_front_value  (o_rsp.front_value),
    .i_rear_value   (o_rsp.rear_value),
    .i_values_valid (o_rsp.values_valid),
    .i_is_empty     (o_rsp.is_empty),
    .i_is_full      (o_rsp.is_full)
);
